>>> hw/rtl/sss_pkg.sv
package sss_pkg;

   // field widths fixed by the transaction format
   localparam int OP_W       = 2;
   localparam int OWNER_ID_W = 16;
   localparam int SHARE_W    = 8;
   localparam int CIDX_W     = 6;
   localparam int MASK_W     = 64;
   localparam int STATUS_W   = 3;
   localparam int TICK_W     = 7;
   localparam int NUM_W      = 30;
   localparam int PASS_W     = 31;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // operations
   localparam logic [OP_W-1:0] OP_SET    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CHARGE = 2'd2;
   localparam logic [OP_W-1:0] OP_PICK   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SHARE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUMERATOR  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_LIMIT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_LIM  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_TIX  = 4'd3;

   localparam logic [NUM_W-1:0]  RST_NUMERATOR  = 30'd1000000;
   localparam logic [NUM_W-1:0]  RST_PASS_LIMIT = 30'd100000000;
   localparam logic [TICK_W-1:0] RST_SHARE_LIM  = 7'd80;
   localparam logic [TICK_W-1:0] RST_TOTAL_TIX  = 7'd100;

   typedef struct packed {
      logic                load;
      logic                scan_clr;
      logic                scan_step;
      logic                rd_en;
      logic                rd_charge;
      logic                status_we;
      logic [STATUS_W-1:0] status;
      logic                div_start;
      logic                div_bg;
      logic                div_keep;
      logic                ss_commit;
      logic                rm_commit;
      logic                ch_commit;
      logic                pk_eval;
      logic                pk_finish;
      logic                out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            share_bad;
      logic            over_limit;
      logic            cnt_end;
      logic            slot_free;
      logic            cbg;
      logic            cidx_out;
      logic            owner_hit;
      logic            rd_last;
      logic            div_done;
   } st_type;

endpackage

>>> hw/rtl/sss_ifs.sv
interface sss_req_if import sss_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [OP_W-1:0]             op;
   logic [OWNER_ID_W-1:0]       owner_id;
   logic signed [SHARE_W-1:0]   share;
   logic                        charge_background;
   logic [CIDX_W-1:0]           charge_index;
   logic [MASK_W-1:0]           runnable_mask;
   logic                        background_runnable;

   modport source (output valid, op, owner_id, share, charge_background, charge_index,
                   runnable_mask, background_runnable, input ready);
   modport sink   (input valid, op, owner_id, share, charge_background, charge_index,
                   runnable_mask, background_runnable, output ready);
endinterface

interface sss_rsp_if import sss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [TICK_W-1:0]     granted_share;
   logic                  pick_background;
   logic [CIDX_W-1:0]     picked_index;
   logic [OWNER_ID_W-1:0] picked_owner;

   modport source (output valid, status, granted_share, pick_background, picked_index,
                   picked_owner, input ready);
   modport sink   (input valid, status, granted_share, pick_background, picked_index,
                   picked_owner, output ready);
endinterface

interface sss_csr_if import sss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/stride_share_scheduler.sv
// One request in work at a time; the next one is taken in the cycle after the
// result enters the output register, even while that result waits.
// Scans walk the entry memory one entry per cycle; set_share runs two 30-step divides.
// Reset (synchronous, high) empties the table, zeroes passes, loads register defaults.
module stride_share_scheduler import sss_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int OWNER_BITS    = 16
) (
   input logic      clock,
   input logic      reset,
   sss_req_if.sink   req_bus,
   sss_rsp_if.source rsp_bus,
   sss_csr_if.sink   csr_bus
);

   cmd_type cmd;
   st_type  st;

   // register writes are always taken; software writes only while idle
   assign csr_bus.ready = 1'b1;

   // controller: sequences each transaction and owns the handshakes
   sss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .st        (st)
   );

   // datapath: entry table, background entry, divider, pick compare
   sss_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .OWNER_BITS    (OWNER_BITS)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .csr_we                  (csr_bus.valid),
      .csr_index               (csr_bus.index),
      .csr_data                (csr_bus.data),
      .req_op                  (req_bus.op),
      .req_owner_id            (req_bus.owner_id),
      .req_share               (req_bus.share),
      .req_charge_background   (req_bus.charge_background),
      .req_charge_index        (req_bus.charge_index),
      .req_runnable_mask       (req_bus.runnable_mask),
      .req_background_runnable (req_bus.background_runnable),
      .cmd                     (cmd),
      .st                      (st),
      .rsp_status              (rsp_bus.status),
      .rsp_granted_share       (rsp_bus.granted_share),
      .rsp_pick_background     (rsp_bus.pick_background),
      .rsp_picked_index        (rsp_bus.picked_index),
      .rsp_picked_owner        (rsp_bus.picked_owner)
   );

endmodule

>>> hw/rtl/sss_div.sv
module sss_div import sss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [TICK_W-1:0] divisor,
   output logic              done,
   output logic [NUM_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TICK_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [TICK_W-1:0] dvs_ff, dvs_in;

   logic [TICK_W:0]   rem_sh;
   logic [TICK_W:0]   diff;
   logic              ge;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/sss_datapath.sv
module sss_datapath import sss_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int OWNER_BITS    = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // register writes
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   // request payload
   input  logic [OP_W-1:0]           req_op,
   input  logic [OWNER_ID_W-1:0]     req_owner_id,
   input  logic signed [SHARE_W-1:0] req_share,
   input  logic                      req_charge_background,
   input  logic [CIDX_W-1:0]         req_charge_index,
   input  logic [MASK_W-1:0]         req_runnable_mask,
   input  logic                      req_background_runnable,
   // control
   input  cmd_type                   cmd,
   output st_type                    st,
   // response payload
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [TICK_W-1:0]         rsp_granted_share,
   output logic                      rsp_pick_background,
   output logic [CIDX_W-1:0]         rsp_picked_index,
   output logic [OWNER_ID_W-1:0]     rsp_picked_owner
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   // configuration
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  plim_ff;
   logic [TICK_W-1:0] slim_ff;
   logic [TICK_W-1:0] tot_ff;

   // captured request
   logic [OP_W-1:0]           op_ff;
   logic [OWNER_BITS-1:0]     owner_ff;
   logic signed [SHARE_W-1:0] share_ff;
   logic                      cbg_ff;
   logic [CIDX_W-1:0]         cidx_ff;
   logic [MASK_W-1:0]         mask_ff;
   logic                      bgrun_ff;

   // table state
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] zpass_ff, zpass_in;   // set: pass reads as zero
   logic [OWNER_BITS-1:0]    mem_owner  [TABLE_ENTRIES];
   logic [TICK_W-1:0]        mem_tick   [TABLE_ENTRIES];
   logic [NUM_W-1:0]         mem_stride [TABLE_ENTRIES];
   logic [PASS_W-1:0]        mem_pass   [TABLE_ENTRIES];

   logic [NUM_W-1:0]  bg_stride_ff, bg_stride_in;
   logic [PASS_W-1:0] bg_pass_ff, bg_pass_in;
   logic [TICK_W-1:0] sum_ff, sum_in;       // tickets held by valid entries
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // read port
   logic                  rd_vld_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [OWNER_BITS-1:0] rd_owner_ff;
   logic [TICK_W-1:0]     rd_tick_ff;
   logic [NUM_W-1:0]      rd_stride_ff;
   logic [PASS_W-1:0]     rd_pass_raw_ff;
   logic                  rd_z_ff;

   // pick scan
   logic [PASS_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]      choice_ff, choice_in;
   logic                  isbg_ff, isbg_in;
   logic [OWNER_BITS-1:0] bown_ff, bown_in;

   logic [NUM_W-1:0] q_bg_ff;

   // result and output registers
   logic [STATUS_W-1:0]   res_status_ff;
   logic [TICK_W-1:0]     res_granted_ff;
   logic                  res_pbg_ff;
   logic [CIDX_W-1:0]     res_pidx_ff;
   logic [OWNER_ID_W-1:0] res_pown_ff;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [TICK_W-1:0]     out_granted_ff;
   logic                  out_pbg_ff;
   logic [CIDX_W-1:0]     out_pidx_ff;
   logic [OWNER_ID_W-1:0] out_pown_ff;

   logic [TICK_W:0]       total;
   logic [TICK_W-1:0]     bgt;
   logic [TICK_W-1:0]     div_dvs;
   logic                  div_done;
   logic [NUM_W-1:0]      div_q;
   logic [IDX_W-1:0]      cnt_idx;
   logic [IDX_W-1:0]      ch_idx;
   logic [IDX_W-1:0]      rd_addr;
   logic [TABLE_ENTRIES-1:0] mask_ext;
   logic [PASS_W-1:0]     pass_rd;
   logic [PASS_W-1:0]     ent_new;
   logic [PASS_W-1:0]     bg_new;
   logic [PASS_W-1:0]     p_new;
   logic                  over_p;
   logic [PASS_W-1:0]     b0;
   logic [IDX_W-1:0]      c0;
   logic                  g0;
   logic [OWNER_BITS-1:0] o0;
   logic                  cand;
   logic                  pbg;

   // runnable bits exist only for the first 64 entries
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_mask
      if (i < MASK_W) begin : g_in
         assign mask_ext[i] = mask_ff[i];
      end else begin : g_out
         assign mask_ext[i] = 1'b0;
      end
   end

   assign total   = {1'b0, share_ff[TICK_W-1:0]} + {1'b0, sum_ff};
   assign bgt     = ({1'b0, tot_ff} > total) ? TICK_W'({1'b0, tot_ff} - total) : '0;
   assign div_dvs = cmd.div_bg ? ((bgt == '0) ? TICK_W'(1) : bgt) : share_ff[TICK_W-1:0];
   assign cnt_idx = cnt_ff[IDX_W-1:0];
   assign ch_idx  = IDX_W'(cidx_ff);
   assign rd_addr = cmd.rd_charge ? ch_idx : cnt_idx;
   assign pass_rd = rd_z_ff ? '0 : rd_pass_raw_ff;

   assign ent_new = PASS_W'(pass_rd + {1'b0, rd_stride_ff});
   assign bg_new  = PASS_W'(bg_pass_ff + {1'b0, bg_stride_ff});
   assign p_new   = cbg_ff ? bg_new : ent_new;
   assign over_p  = p_new > {1'b0, plim_ff};

   assign st.op         = op_ff;
   assign st.share_bad  = share_ff[SHARE_W-1] || (share_ff == '0);
   assign st.over_limit = total > {1'b0, slim_ff};
   assign st.cnt_end    = cnt_ff == CNT_END;
   assign st.slot_free  = (cnt_ff != CNT_END) && !valid_ff[cnt_idx];
   assign st.cbg        = cbg_ff;
   assign st.cidx_out   = 9'(cidx_ff) >= 9'(TABLE_ENTRIES);
   assign st.owner_hit  = rd_vld_ff && valid_ff[rd_idx_ff] && (rd_owner_ff == owner_ff);
   assign st.rd_last    = rd_vld_ff && (rd_idx_ff == IDX_LAST);
   assign st.div_done   = div_done;

   sss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // state updates
   always_comb begin
      valid_in     = valid_ff;
      zpass_in     = zpass_ff;
      bg_stride_in = bg_stride_ff;
      bg_pass_in   = bg_pass_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      if (cmd.scan_clr) begin
         cnt_in = '0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.ss_commit) begin
         valid_in[cnt_idx] = 1'b1;
         zpass_in          = zpass_ff | valid_ff;
         zpass_in[cnt_idx] = 1'b1;
         bg_stride_in      = q_bg_ff;
         bg_pass_in        = '0;
         sum_in            = total[TICK_W-1:0];
      end
      if (cmd.rm_commit) begin
         valid_in[rd_idx_ff] = 1'b0;
         sum_in              = sum_ff - rd_tick_ff;
      end
      if (cmd.ch_commit) begin
         if (cbg_ff) begin
            bg_pass_in = bg_new;
         end else begin
            zpass_in[rd_idx_ff] = 1'b0;
         end
         if (over_p) begin
            bg_pass_in = '0;
            zpass_in   = zpass_in | valid_ff;
         end
      end
   end

   // pick compare; entry 0 seeds the choice when the background is idle
   always_comb begin
      if (rd_idx_ff == '0) begin
         b0 = bgrun_ff ? bg_pass_ff : pass_rd;
         c0 = '0;
         g0 = bgrun_ff;
         o0 = bgrun_ff ? '0 : rd_owner_ff;
      end else begin
         b0 = best_ff;
         c0 = choice_ff;
         g0 = isbg_ff;
         o0 = bown_ff;
      end
      cand = valid_ff[rd_idx_ff] && mask_ext[rd_idx_ff];
      if (cand && (pass_rd < b0)) begin
         best_in   = pass_rd;
         choice_in = rd_idx_ff;
         isbg_in   = 1'b0;
         bown_in   = rd_owner_ff;
      end else begin
         best_in   = b0;
         choice_in = c0;
         isbg_in   = g0;
         bown_in   = o0;
      end
   end

   assign pbg = isbg_ff || !valid_ff[choice_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= RST_NUMERATOR;
         plim_ff      <= RST_PASS_LIMIT;
         slim_ff      <= RST_SHARE_LIM;
         tot_ff       <= RST_TOTAL_TIX;
         valid_ff     <= '0;
         zpass_ff     <= '1;
         bg_stride_ff <= '0;
         bg_pass_ff   <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUMERATOR:  num_ff  <= csr_data[NUM_W-1:0];
               CSR_PASS_LIMIT: plim_ff <= csr_data[NUM_W-1:0];
               CSR_SHARE_LIM:  slim_ff <= csr_data[TICK_W-1:0];
               CSR_TOTAL_TIX:  tot_ff  <= csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         valid_ff     <= valid_in;
         zpass_ff     <= zpass_in;
         bg_stride_ff <= bg_stride_in;
         bg_pass_ff   <= bg_pass_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= cmd.rd_en;
      end
   end

   // entry memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.ss_commit) begin
         mem_owner[cnt_idx]  <= owner_ff;
         mem_tick[cnt_idx]   <= share_ff[TICK_W-1:0];
         mem_stride[cnt_idx] <= div_q;
      end
      if (cmd.ch_commit && !cbg_ff) begin
         mem_pass[rd_idx_ff] <= ent_new;
      end
      if (cmd.rd_en) begin
         rd_idx_ff      <= rd_addr;
         rd_owner_ff    <= mem_owner[rd_addr];
         rd_tick_ff     <= mem_tick[rd_addr];
         rd_stride_ff   <= mem_stride[rd_addr];
         rd_pass_raw_ff <= mem_pass[rd_addr];
         rd_z_ff        <= zpass_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff          <= req_op;
         owner_ff       <= OWNER_BITS'(req_owner_id);
         share_ff       <= req_share;
         cbg_ff         <= req_charge_background;
         cidx_ff        <= req_charge_index;
         mask_ff        <= req_runnable_mask;
         bgrun_ff       <= req_background_runnable;
         res_status_ff  <= ST_OK;
         res_granted_ff <= '0;
         res_pbg_ff     <= 1'b0;
         res_pidx_ff    <= '0;
         res_pown_ff    <= '0;
      end
      if (cmd.status_we) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.ss_commit) begin
         res_granted_ff <= share_ff[TICK_W-1:0];
      end
      if (cmd.div_keep) begin
         q_bg_ff <= div_q;
      end
      if (cmd.pk_eval && rd_vld_ff) begin
         best_ff   <= best_in;
         choice_ff <= choice_in;
         isbg_ff   <= isbg_in;
         bown_ff   <= bown_in;
      end
      if (cmd.pk_finish) begin
         res_pbg_ff  <= pbg;
         res_pidx_ff <= pbg ? '0 : CIDX_W'(choice_ff);
         res_pown_ff <= pbg ? '0 : OWNER_ID_W'(bown_ff);
      end
      if (cmd.out_load) begin
         out_status_ff  <= res_status_ff;
         out_granted_ff <= res_granted_ff;
         out_pbg_ff     <= res_pbg_ff;
         out_pidx_ff    <= res_pidx_ff;
         out_pown_ff    <= res_pown_ff;
      end
   end

   assign rsp_status          = out_status_ff;
   assign rsp_granted_share   = out_granted_ff;
   assign rsp_pick_background = out_pbg_ff;
   assign rsp_picked_index    = out_pidx_ff;
   assign rsp_picked_owner    = out_pown_ff;

endmodule

>>> hw/rtl/sss_ctrl.sv
module sss_ctrl import sss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  st_type  st
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_SS_SCAN   = 4'd2;
   localparam logic [3:0] S_DIV_BG    = 4'd3;
   localparam logic [3:0] S_DIV_EN    = 4'd4;
   localparam logic [3:0] S_RM_SCAN   = 4'd5;
   localparam logic [3:0] S_CH_WRITE  = 4'd6;
   localparam logic [3:0] S_PK_SCAN   = 4'd7;
   localparam logic [3:0] S_PK_DONE   = 4'd8;
   localparam logic [3:0] S_FIN       = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = state_ff == S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (st.op)
               OP_SET: begin
                  if (st.share_bad) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_BAD_SHARE;
                     state_in      = S_FIN;
                  end else if (st.over_limit) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_OVER;
                     state_in      = S_FIN;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_SS_SCAN;
                  end
               end
               OP_REMOVE: begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_RM_SCAN;
               end
               OP_CHARGE: begin
                  if (!st.cbg && st.cidx_out) begin
                     state_in = S_FIN;
                  end else begin
                     cmd.rd_en     = 1'b1;
                     cmd.rd_charge = 1'b1;
                     state_in      = S_CH_WRITE;
                  end
               end
               OP_PICK: begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_PK_SCAN;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_SS_SCAN: begin
            if (st.cnt_end) begin
               cmd.status_we = 1'b1;
               cmd.status    = ST_FULL;
               state_in      = S_FIN;
            end else if (st.slot_free) begin
               cmd.div_start = 1'b1;
               cmd.div_bg    = 1'b1;
               state_in      = S_DIV_BG;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_DIV_BG: begin
            cmd.div_bg = 1'b1;
            if (st.div_done) begin
               cmd.div_keep  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_bg    = 1'b0;
               state_in      = S_DIV_EN;
            end
         end
         S_DIV_EN: begin
            if (st.div_done) begin
               cmd.ss_commit = 1'b1;
               state_in      = S_FIN;
            end
         end
         S_RM_SCAN: begin
            cmd.rd_en     = !st.cnt_end;
            cmd.scan_step = !st.cnt_end;
            if (st.owner_hit) begin
               cmd.rm_commit = 1'b1;
               state_in      = S_FIN;
            end else if (st.rd_last) begin
               cmd.status_we = 1'b1;
               cmd.status    = ST_NOT_FOUND;
               state_in      = S_FIN;
            end
         end
         S_CH_WRITE: begin
            cmd.ch_commit = 1'b1;
            state_in      = S_FIN;
         end
         S_PK_SCAN: begin
            cmd.rd_en     = !st.cnt_end;
            cmd.scan_step = !st.cnt_end;
            cmd.pk_eval   = 1'b1;
            if (st.rd_last) begin
               state_in = S_PK_DONE;
            end
         end
         S_PK_DONE: begin
            cmd.pk_finish = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/sss_checker.sv
module sss_checker import sss_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [TICK_W-1:0]     rsp_granted_share,
   input logic                  rsp_pick_background,
   input logic [CIDX_W-1:0]     rsp_picked_index,
   input logic [OWNER_ID_W-1:0] rsp_picked_owner
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_share != '0 |-> rsp_status == ST_OK)
      else $error("grant with failing status");

   a_bg_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pick_background |-> rsp_picked_index == '0 && rsp_picked_owner == '0)
      else $error("background pick carries an entry");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stride_share_scheduler sss_checker u_sss_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_status          (rsp_bus.status),
   .rsp_granted_share   (rsp_bus.granted_share),
   .rsp_pick_background (rsp_bus.pick_background),
   .rsp_picked_index    (rsp_bus.picked_index),
   .rsp_picked_owner    (rsp_bus.picked_owner)
);

>>> bench/sss_sched_checker.sv
`timescale 1ns / 1ps

module sss_sched_checker import sss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sss_req_if          req_bus,
   sss_rsp_if          rsp_bus,
   sss_csr_if          csr_bus,
   output int          fail_count,
   output int          pending,
   output logic [63:0] written_mask,
   output logic [63:0] live_mask,
   output logic [OWNER_ID_W-1:0] live_owner [64]
);

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [TICK_W-1:0]     granted;
      logic                  pick_bg;
      logic [CIDX_W-1:0]     index;
      logic [OWNER_ID_W-1:0] owner;
   } sched_result_type;

   sched_result_type verdicts_due [$];

   logic [NUM_W-1:0]  numerator;
   logic [NUM_W-1:0]  pass_limit;
   logic [TICK_W-1:0] share_limit;
   logic [TICK_W-1:0] pool_tickets;

   logic [TICK_W-1:0] tickets [64];
   logic [NUM_W-1:0]  stride [64];
   logic [PASS_W-1:0] pass [64];
   logic [TICK_W-1:0] bg_tickets;
   logic [NUM_W-1:0]  bg_stride;
   logic [PASS_W-1:0] bg_pass;

   assign pending = verdicts_due.size();

   task automatic clear_passes();
      bg_pass = '0;
      for (int i = 0; i < 64; i++)
         if (live_mask[i]) pass[i] = '0;
   endtask

   // advance the table for one transaction and return the response it owes
   task automatic schedule_step(output sched_result_type r);
      int                total;
      int                slot;
      logic [PASS_W-1:0] p;
      logic [PASS_W-1:0] best;
      int                choice;
      logic              on_bg;
      r = '0;
      case (req_bus.op)
         OP_SET: begin
            total = 0;
            slot = -1;
            for (int i = 0; i < 64; i++) begin
               if (live_mask[i]) total += tickets[i];
               else if (slot < 0) slot = i;
            end
            total += req_bus.share;
            if (req_bus.share <= 0) r.status = ST_BAD_SHARE;
            else if (total > share_limit) r.status = ST_OVER;
            else if (slot < 0) r.status = ST_FULL;
            else begin
               bg_tickets = (pool_tickets > total) ? TICK_W'(pool_tickets - total) : '0;
               bg_stride = numerator / ((bg_tickets != 0) ? bg_tickets : 7'd1);
               clear_passes();
               live_mask[slot] = 1'b1;
               written_mask[slot] = 1'b1;
               live_owner[slot] = req_bus.owner_id;
               tickets[slot] = TICK_W'(req_bus.share);
               stride[slot] = numerator / TICK_W'(req_bus.share);
               pass[slot] = '0;
               r.granted = TICK_W'(req_bus.share);
            end
         end
         OP_REMOVE: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < 64; i++)
               if (r.status == ST_NOT_FOUND && live_mask[i] &&
                   live_owner[i] == req_bus.owner_id) begin
                  live_mask[i] = 1'b0;
                  r.status = ST_OK;
               end
         end
         OP_CHARGE: begin
            if (req_bus.charge_background) begin
               bg_pass = bg_pass + bg_stride;
               p = bg_pass;
            end else begin
               pass[req_bus.charge_index] = pass[req_bus.charge_index] +
                                            stride[req_bus.charge_index];
               p = pass[req_bus.charge_index];
            end
            if (p > pass_limit) clear_passes();
         end
         default: begin
            on_bg = req_bus.background_runnable;
            choice = 0;
            best = on_bg ? bg_pass : pass[0];
            for (int i = 0; i < 64; i++)
               if (live_mask[i] && req_bus.runnable_mask[i] && pass[i] < best) begin
                  best = pass[i];
                  choice = i;
                  on_bg = 1'b0;
               end
            if (on_bg || !live_mask[choice]) r.pick_bg = 1'b1;
            else begin
               r.index = CIDX_W'(choice);
               r.owner = live_owner[choice];
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      sched_result_type want, got;
      if (reset) begin
         verdicts_due = {};
         fail_count <= 0;
         numerator = RST_NUMERATOR;
         pass_limit = RST_PASS_LIMIT;
         share_limit = RST_SHARE_LIM;
         pool_tickets = RST_TOTAL_TIX;
         live_mask = '0;
         written_mask = '0;
         bg_tickets = '0;
         bg_stride = '0;
         bg_pass = '0;
         for (int i = 0; i < 64; i++) begin
            pass[i] = '0;
            tickets[i] = '0;
            stride[i] = '0;
            live_owner[i] = '0;
         end
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.status, rsp_bus.granted_share, rsp_bus.pick_background,
                    rsp_bus.picked_index, rsp_bus.picked_owner};
            if (verdicts_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t unexpected response %p", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = verdicts_due.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t response mismatch: expected %p, got %p",
                              $realtime, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            schedule_step(want);
            verdicts_due.push_back(want);
         end
         if (csr_bus.valid && csr_bus.ready)
            case (csr_bus.index)
               CSR_NUMERATOR:  numerator = csr_bus.data[NUM_W-1:0];
               CSR_PASS_LIMIT: pass_limit = csr_bus.data[NUM_W-1:0];
               CSR_SHARE_LIM:  share_limit = csr_bus.data[TICK_W-1:0];
               CSR_TOTAL_TIX:  pool_tickets = csr_bus.data[TICK_W-1:0];
               default: ;
            endcase
      end
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sss_pkg::*;

   localparam int PHASE_ITEMS = 300;
   localparam int CYCLE_LIMIT = 1200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;   // no idling on either side once set
   int   cycles = 0;
   int   fail_count;
   int   pending;
   logic [63:0]           written_mask;
   logic [63:0]           live_mask;
   logic [OWNER_ID_W-1:0] live_owner [64];

   sss_req_if req_bus ();
   sss_rsp_if rsp_bus ();
   sss_csr_if csr_bus ();

   stride_share_scheduler u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sss_sched_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_bus      (csr_bus),
      .fail_count   (fail_count),
      .pending      (pending),
      .written_mask (written_mask),
      .live_mask    (live_mask),
      .live_owner   (live_owner)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // response side backpressure: ready drops in random stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_bus.ready <= !reset;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // one request transaction; valid stays high into the next call
   task automatic send_req(logic [OP_W-1:0] op, logic [OWNER_ID_W-1:0] owner,
                           logic signed [SHARE_W-1:0] share, logic cbg,
                           logic [CIDX_W-1:0] cidx, logic [MASK_W-1:0] mask, logic bgr);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.op                  <= op;
      req_bus.owner_id            <= owner;
      req_bus.share               <= share;
      req_bus.charge_background   <= cbg;
      req_bus.charge_index        <= cidx;
      req_bus.runnable_mask       <= mask;
      req_bus.background_runnable <= bgr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // sender holds off until every response is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // valid stays high into the next write; the caller drops it after the last one
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   function automatic logic [MASK_W-1:0] some_mask();
      case ($urandom_range(0, 5))
         0:       return '1;
         1:       return '0;
         2:       return {$urandom, $urandom} & {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random transaction; charges only hit entries that were written at least once
   task automatic send_random();
      logic [OP_W-1:0]           op;
      logic [OWNER_ID_W-1:0]     owner;
      logic signed [SHARE_W-1:0] share;
      logic                      cbg;
      int                        idx;
      op = OP_PICK;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5:   op = OP_SET;
         6, 7, 8, 9:         op = OP_REMOVE;
         10, 11, 12, 13, 14: op = OP_CHARGE;
         default:            op = OP_PICK;
      endcase
      owner = ($urandom_range(0, 3) != 0) ? OWNER_ID_W'($urandom_range(0, 7)) :
                                            OWNER_ID_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0, 1:    share = SHARE_W'($urandom_range(0, 255));
         2:       share = SHARE_W'($urandom_range(5, 127));
         default: share = SHARE_W'($urandom_range(1, 4));
      endcase
      idx = $urandom_range(0, 63);
      cbg = ($urandom_range(0, 2) == 0) || (written_mask == '0);
      if (!cbg)
         while (!written_mask[idx]) idx = (idx + 1) % 64;
      send_req(op, owner, share, cbg, CIDX_W'(idx), some_mask(), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      logic [NUM_W-1:0]  cfg_num   [6];
      logic [NUM_W-1:0]  cfg_limit [6];
      logic [TICK_W-1:0] cfg_share [6];
      logic [TICK_W-1:0] cfg_pool  [6];

      req_bus.valid = 1'b0;
      req_bus.op = OP_SET;
      req_bus.owner_id = '0;
      req_bus.share = '0;
      req_bus.charge_background = 1'b0;
      req_bus.charge_index = '0;
      req_bus.runnable_mask = '0;
      req_bus.background_runnable = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_NUMERATOR;
      csr_bus.data = '0;

      // phase settings: big pool for filling, minimums, maximums, odd, random, defaults
      cfg_num   = '{30'd1000000, 30'd1, 30'h3FFFFFFF, 30'd5000,
                    NUM_W'($urandom_range(1, 32'h3FFFFFFF)), RST_NUMERATOR};
      cfg_limit = '{30'd100000000, 30'd1, 30'h3FFFFFFF, 30'd20000,
                    NUM_W'($urandom_range(1, 1 << 20)), RST_PASS_LIMIT};
      cfg_share = '{7'd127, 7'd1, 7'd127, 7'd30,
                    TICK_W'($urandom_range(1, 127)), RST_SHARE_LIM};
      cfg_pool  = '{7'd100, 7'd1, 7'd127, 7'd40,
                    TICK_W'($urandom_range(1, 127)), RST_TOTAL_TIX};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: picks on an empty table, bad shares, limits
      send_req(OP_PICK, 16'h0000, 8'sd0, 1'b0, 6'd0, '1, 1'b0);   // invalid entry 0 -> bg
      send_req(OP_PICK, 16'hFFFF, 8'sd0, 1'b1, 6'd63, '0, 1'b1);
      send_req(OP_SET, 16'h0001, 8'sd0, 1'b0, 6'd0, '0, 1'b0);    // zero share
      send_req(OP_SET, 16'h0001, -8'sd128, 1'b0, 6'd0, '0, 1'b0); // most negative
      send_req(OP_SET, 16'h0001, -8'sd1, 1'b0, 6'd0, '0, 1'b0);
      send_req(OP_SET, 16'h0001, 8'sd127, 1'b0, 6'd0, '0, 1'b0);  // over share limit
      send_req(OP_REMOVE, 16'h0001, 8'sd0, 1'b0, 6'd0, '0, 1'b0); // not found
      send_req(OP_SET, 16'hFFFF, 8'sd80, 1'b0, 6'd0, '0, 1'b0);   // exactly at limit
      send_req(OP_SET, 16'h0002, 8'sd1, 1'b0, 6'd0, '0, 1'b0);    // now over
      send_req(OP_CHARGE, 16'h0000, 8'sd0, 1'b1, 6'd0, '0, 1'b0); // background
      send_req(OP_CHARGE, 16'h0000, 8'sd0, 1'b0, 6'd0, '0, 1'b0); // entry 0
      send_req(OP_PICK, 16'h0000, 8'sd0, 1'b0, 6'd0, '1, 1'b1);
      send_req(OP_PICK, 16'h0000, 8'sd0, 1'b0, 6'd0, '1, 1'b0);
      send_req(OP_REMOVE, 16'hFFFF, 8'sd0, 1'b0, 6'd0, '0, 1'b0);
      send_req(OP_SET, 16'h0000, 8'sd3, 1'b0, 6'd0, '0, 1'b0);
      send_req(OP_SET, 16'h0000, 8'sd5, 1'b0, 6'd0, '0, 1'b0);    // duplicate owner
      send_req(OP_CHARGE, 16'h0000, 8'sd0, 1'b0, 6'd1, '0, 1'b0);
      send_req(OP_PICK, 16'h0000, 8'sd0, 1'b0, 6'd0, 64'h2, 1'b1);
      send_req(OP_REMOVE, 16'h0000, 8'sd0, 1'b0, 6'd0, '0, 1'b0); // lowest match
      send_req(OP_CHARGE, 16'h0000, 8'sd0, 1'b0, 6'd0, '0, 1'b0); // removed entry
      send_req(OP_PICK, 16'h0000, 8'sd0, 1'b0, 6'd0, '1, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         csr_write(CSR_NUMERATOR, 32'(cfg_num[ph]));
         csr_write(CSR_PASS_LIMIT, 32'(cfg_limit[ph]));
         csr_write(CSR_SHARE_LIM, 32'(cfg_share[ph]));
         csr_write(CSR_TOTAL_TIX, 32'(cfg_pool[ph]));
         csr_bus.valid <= 1'b0;
         if (ph == 5) quiet = 1'b1;
         if (ph == 0) begin
            // empty the table, then fill it with one-ticket owners past full
            while (live_mask != '0) begin
               for (int i = 0; i < 64; i++)
                  if (live_mask[i]) begin
                     send_req(OP_REMOVE, live_owner[i], 8'sd0, 1'b0, 6'd0, '0, 1'b0);
                     break;
                  end
               drain();
            end
            for (int i = 0; i < 66; i++)
               send_req(OP_SET, 16'(i % 9), 8'sd1, 1'b0, 6'd0, '0, 1'b0);
            send_req(OP_SET, 16'h00AA, 8'sd100, 1'b0, 6'd0, '0, 1'b0);
            send_req(OP_PICK, 16'h0000, 8'sd0, 1'b0, 6'd0, '1, 1'b1);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      end

      drain();
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
